// File: hw/rtl/ostt_pkg.sv
// ----------------------------------------------------------------------------
// ostt_pkg
// Shared constants, codes and control types for the one-shot timer table.
// ----------------------------------------------------------------------------
`default_nettype none

package ostt_pkg;

  localparam int SLOT_COUNT = 64;
  localparam int IDX_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int ID_W       = 6;
  localparam int DATA_W     = 32;
  localparam int MODE_W     = 2;
  localparam int STATUS_W   = 3;

  localparam logic [DATA_W-1:0] MIN_INTERVAL_RESET = DATA_W'(10);

  typedef enum logic [MODE_W-1:0] {
    MODE_SET   = 2'd0,
    MODE_CLEAR = 2'd1,
    MODE_POLL  = 2'd2
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_SET_OK  = 3'd0,
    ST_FULL    = 3'd1,
    ST_CLEARED = 3'd2,
    ST_EXPIRED = 3'd3,
    ST_NONE    = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SET,
    S_CLEAR,
    S_POLL,
    S_POLL_TAIL,
    S_POLL_END
  } state_t;

  typedef struct packed {
    logic load;
    logic set_step;
    logic clear_do;
    logic poll_issue;
    logic poll_end;
  } cmd_t;

  typedef struct packed {
    logic cur_free;
    logic idx_last;
  } stat_t;

endpackage

`default_nettype wire

// File: hw/rtl/ostt_ctrl.sv
// ----------------------------------------------------------------------------
// ostt_ctrl
// Sequencer for the timer table: decodes the item mode and steps the scan.
// ----------------------------------------------------------------------------
`default_nettype none

module ostt_ctrl (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [ostt_pkg::MODE_W-1:0] mode,
  input  wire ostt_pkg::stat_t            stat,
  output logic                            busy,
  output ostt_pkg::cmd_t                  cmd
);

  ostt_pkg::state_t state;
  ostt_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ostt_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ostt_pkg::S_IDLE: begin
        if (start) begin
          case (ostt_pkg::mode_t'(mode))
            ostt_pkg::MODE_SET:   state_next = ostt_pkg::S_SET;
            ostt_pkg::MODE_CLEAR: state_next = ostt_pkg::S_CLEAR;
            ostt_pkg::MODE_POLL:  state_next = ostt_pkg::S_POLL;
            default:              state_next = ostt_pkg::S_IDLE;
          endcase
        end
      end
      ostt_pkg::S_SET: begin
        if (stat.cur_free || stat.idx_last) begin
          state_next = ostt_pkg::S_IDLE;
        end
      end
      ostt_pkg::S_CLEAR:     state_next = ostt_pkg::S_IDLE;
      ostt_pkg::S_POLL: begin
        if (stat.idx_last) begin
          state_next = ostt_pkg::S_POLL_TAIL;
        end
      end
      // last read still in the compare stage
      ostt_pkg::S_POLL_TAIL: state_next = ostt_pkg::S_POLL_END;
      ostt_pkg::S_POLL_END:  state_next = ostt_pkg::S_IDLE;
      default:               state_next = ostt_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state)
      ostt_pkg::S_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      ostt_pkg::S_SET:       cmd.set_step   = 1'b1;
      ostt_pkg::S_CLEAR:     cmd.clear_do   = 1'b1;
      ostt_pkg::S_POLL:      cmd.poll_issue = 1'b1;
      ostt_pkg::S_POLL_TAIL: cmd            = '0;
      ostt_pkg::S_POLL_END:  cmd.poll_end   = 1'b1;
      default:               cmd            = '0;
    endcase
  end

endmodule

`default_nettype wire

// File: hw/rtl/ostt_dp.sv
// ----------------------------------------------------------------------------
// ostt_dp
// Datapath: slot valid bits, deadline memory, scan counter, compare stage
// and the registered result port.
// ----------------------------------------------------------------------------
`default_nettype none

module ostt_dp (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire ostt_pkg::cmd_t                cmd,
  output ostt_pkg::stat_t                    stat,
  input  wire logic [ostt_pkg::DATA_W-1:0]   interval,
  input  wire logic [ostt_pkg::ID_W-1:0]     slot_id,
  input  wire logic [ostt_pkg::DATA_W-1:0]   now_ms,
  input  wire logic                          cfg_we,
  input  wire logic [ostt_pkg::DATA_W-1:0]   cfg_data,
  output logic                               result_strobe,
  output logic [ostt_pkg::STATUS_W-1:0]      status,
  output logic [ostt_pkg::ID_W-1:0]          slot,
  output logic                               last
);

  localparam logic [ostt_pkg::IDX_W-1:0] IDX_END = ostt_pkg::IDX_W'(ostt_pkg::SLOT_COUNT - 1);

  logic [ostt_pkg::DATA_W-1:0]     min_interval;
  logic [ostt_pkg::SLOT_COUNT-1:0] valid;
  logic [ostt_pkg::DATA_W-1:0]     deadline_mem [ostt_pkg::SLOT_COUNT];

  logic [ostt_pkg::DATA_W-1:0] now_r;
  logic [ostt_pkg::DATA_W-1:0] eff_r;
  logic [ostt_pkg::ID_W-1:0]   slot_id_r;
  logic [ostt_pkg::IDX_W-1:0]  idx;

  // compare stage
  logic                        p_act;
  logic                        p_valid;
  logic [ostt_pkg::IDX_W-1:0]  p_idx;
  logic [ostt_pkg::DATA_W-1:0] rd_data;
  logic                        hit;

  // expired slot held back until we know whether another follows
  logic                        pend_v;
  logic [ostt_pkg::IDX_W-1:0]  pend_idx;

  logic                        clr_in_range;
  logic                        emit_v;
  ostt_pkg::status_t           emit_status;
  logic [ostt_pkg::ID_W-1:0]   emit_slot;
  logic                        emit_last;

  assign stat.cur_free = ~valid[idx];
  assign stat.idx_last = (idx == IDX_END);

  assign hit          = p_act && p_valid && (rd_data <= now_r);
  assign clr_in_range = ({1'b0, slot_id_r} < (ostt_pkg::ID_W + 1)'(ostt_pkg::SLOT_COUNT));

  always_ff @(posedge clk) begin
    if (rst) begin
      min_interval <= ostt_pkg::MIN_INTERVAL_RESET;
    end else if (cfg_we) begin
      min_interval <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      now_r     <= now_ms;
      eff_r     <= (interval < min_interval) ? min_interval : interval;
      slot_id_r <= slot_id;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (cmd.load) begin
      idx <= '0;
    end else if ((cmd.poll_issue || (cmd.set_step && !stat.cur_free)) && !stat.idx_last) begin
      idx <= idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (cmd.set_step && stat.cur_free) begin
        valid[idx] <= 1'b1;
      end
      if (cmd.clear_do && clr_in_range) begin
        valid[slot_id_r[ostt_pkg::IDX_W-1:0]] <= 1'b0;
      end
      if (hit) begin
        valid[p_idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.set_step && stat.cur_free) begin
      deadline_mem[idx] <= now_r + eff_r;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= deadline_mem[idx];
    p_idx   <= idx;
    p_valid <= valid[idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_act <= 1'b0;
    end else begin
      p_act <= cmd.poll_issue;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_v <= 1'b0;
    end else if (cmd.load) begin
      pend_v <= 1'b0;
    end else if (hit) begin
      pend_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (hit) begin
      pend_idx <= p_idx;
    end
  end

  always_comb begin
    emit_v      = 1'b0;
    emit_status = ostt_pkg::ST_SET_OK;
    emit_slot   = '0;
    emit_last   = 1'b1;
    if (cmd.set_step && stat.cur_free) begin
      emit_v    = 1'b1;
      emit_slot = ostt_pkg::ID_W'(idx);
    end else if (cmd.set_step && stat.idx_last) begin
      emit_v      = 1'b1;
      emit_status = ostt_pkg::ST_FULL;
    end else if (cmd.clear_do) begin
      emit_v      = 1'b1;
      emit_status = ostt_pkg::ST_CLEARED;
      emit_slot   = slot_id_r;
    end else if (hit && pend_v) begin
      emit_v      = 1'b1;
      emit_status = ostt_pkg::ST_EXPIRED;
      emit_slot   = ostt_pkg::ID_W'(pend_idx);
      emit_last   = 1'b0;
    end else if (cmd.poll_end) begin
      emit_v = 1'b1;
      if (pend_v) begin
        emit_status = ostt_pkg::ST_EXPIRED;
        emit_slot   = ostt_pkg::ID_W'(pend_idx);
      end else begin
        emit_status = ostt_pkg::ST_NONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= emit_v;
    end
  end

  always_ff @(posedge clk) begin
    status <= emit_status;
    slot   <= emit_slot;
    last   <= emit_last;
  end

endmodule

`default_nettype wire

// File: hw/rtl/one_shot_timer_table.sv
// ----------------------------------------------------------------------------
// one_shot_timer_table
// Table of one-shot millisecond timer slots with set, clear and expiry poll.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. mode 0 sets a timer in
// the lowest free slot (deadline now_ms plus interval, raised to min_interval),
// mode 1 frees slot_id, mode 2 polls every slot and reports each expired one,
// mode 3 is ignored and returns no result.
// Results appear for one cycle with result_strobe high; last marks the final
// result of an item. The receiver cannot stall, so results are never held.
// A set scans from slot 0 to the first free slot; a poll walks every slot
// through the single read port of the deadline memory, one slot a cycle.
// busy drops in the cycle the final result is out, so the next item can be
// taken at the edge that accepts that result.
// Expired results of a poll come out in slot order, each one in the cycle after
// the next hit is found; the final one at the end of the scan.
// min_interval is written on the cfg channel (always ready); the user must
// write it only while idle, which the block itself does not enforce.
// Reset frees every slot and sets min_interval to 10; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module one_shot_timer_table (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [ostt_pkg::MODE_W-1:0]    mode,
  input  wire logic [ostt_pkg::DATA_W-1:0]    interval,
  input  wire logic [ostt_pkg::ID_W-1:0]      slot_id,
  input  wire logic [ostt_pkg::DATA_W-1:0]    now_ms,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [ostt_pkg::DATA_W-1:0]    cfg_data,
  output logic                                result_strobe,
  output logic [ostt_pkg::STATUS_W-1:0]       status,
  output logic [ostt_pkg::ID_W-1:0]           slot,
  output logic                                last
);

  ostt_pkg::cmd_t  cmd;
  ostt_pkg::stat_t stat;

  assign cfg_ready = 1'b1;

  ostt_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .mode  (mode),
    .stat  (stat),
    .busy  (busy),
    .cmd   (cmd)
  );

  ostt_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .interval      (interval),
    .slot_id       (slot_id),
    .now_ms        (now_ms),
    .cfg_we        (cfg_valid & cfg_ready),
    .cfg_data      (cfg_data),
    .result_strobe (result_strobe),
    .status        (status),
    .slot          (slot),
    .last          (last)
  );

endmodule

`default_nettype wire

// File: tb/sv/tb_one_shot_timer_table.sv
// ----------------------------------------------------------------------------
// tb_one_shot_timer_table
// Self-checking bench for the one-shot timer table. A directed table of
// commands, then a table fill to overflow and a poll that expires every
// slot, then random set / clear / poll traffic under several min_interval
// settings. Every result beat is checked against a shadow copy of the table.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_one_shot_timer_table;
  import ostt_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int ITEMS_PER_PHASE = 26;
  localparam int SETTLE_CYCLES = SLOT_COUNT + 8;

  typedef struct {
    logic [MODE_W-1:0] op;
    logic [DATA_W-1:0] ivl;
    logic [ID_W-1:0]   sid;
    logic [DATA_W-1:0] now;
    bit                typed;
    status_t           st;
    logic [ID_W-1:0]   sl;
  } timer_cmd_t;

  typedef struct {
    status_t         st;
    logic [ID_W-1:0] sl;
    logic            fin;
  } timer_report_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [MODE_W-1:0] mode = '0;
  logic [DATA_W-1:0] interval = '0;
  logic [ID_W-1:0] slot_id = '0;
  logic [DATA_W-1:0] now_ms = '0;
  logic cfg_valid = 1'b0;
  logic [DATA_W-1:0] cfg_data = '0;
  logic busy, cfg_ready, result_strobe, last;
  logic [STATUS_W-1:0] status;
  logic [ID_W-1:0] slot;

  // shadow of the timer table
  logic              shadow_live [SLOT_COUNT] = '{default: 1'b0};
  logic [DATA_W-1:0] shadow_deadline [SLOT_COUNT];
  logic [DATA_W-1:0] shadow_min_interval = MIN_INTERVAL_RESET;

  timer_report_t expected_reports[$];
  int mismatch_count = 0;
  bit gaps_on = 1'b1;

  one_shot_timer_table dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .mode(mode),
    .interval(interval), .slot_id(slot_id), .now_ms(now_ms),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .result_strobe(result_strobe), .status(status), .slot(slot), .last(last)
  );

  always #2 clk = ~clk;

  task automatic flag_mismatch(input string what);
    if (mismatch_count < 40) $display("mismatch at %0t: %s", $time, what);
    mismatch_count++;
  endtask

  // applies one command to the shadow table, queues its results
  function automatic int advance_timer_table(timer_cmd_t c);
    int hits;
    int free_idx;
    logic [DATA_W-1:0] span;
    hits = 0;
    free_idx = -1;
    span = c.ivl;
    case (c.op)
      MODE_SET: begin
        for (int i = SLOT_COUNT - 1; i >= 0; i--)
          if (!shadow_live[i]) free_idx = i;
        if (free_idx < 0) begin
          expected_reports.push_back('{ST_FULL, '0, 1'b1});
        end else begin
          if (span < shadow_min_interval) span = shadow_min_interval;
          shadow_deadline[free_idx] = c.now + span;
          shadow_live[free_idx] = 1'b1;
          expected_reports.push_back('{ST_SET_OK, ID_W'(free_idx), 1'b1});
        end
        hits = 1;
      end
      MODE_CLEAR: begin
        if (c.sid < SLOT_COUNT) shadow_live[c.sid] = 1'b0;
        expected_reports.push_back('{ST_CLEARED, c.sid, 1'b1});
        hits = 1;
      end
      MODE_POLL: begin
        for (int i = 0; i < SLOT_COUNT; i++) begin
          if (shadow_live[i] && shadow_deadline[i] <= c.now) begin
            shadow_live[i] = 1'b0;
            expected_reports.push_back('{ST_EXPIRED, ID_W'(i), 1'b0});
            hits++;
          end
        end
        if (hits == 0) begin
          expected_reports.push_back('{ST_NONE, '0, 1'b1});
          hits = 1;
        end else begin
          expected_reports[expected_reports.size() - 1].fin = 1'b1;
        end
      end
      default: ;
    endcase
    return hits;
  endfunction

  // start stays high on return unless gapped, so beats can go back to back
  task automatic send_item(input timer_cmd_t c);
    int n;
    start <= 1'b1;
    mode <= c.op;
    interval <= c.ivl;
    slot_id <= c.sid;
    now_ms <= c.now;
    @(posedge clk);
    while (busy) @(posedge clk);
    n = advance_timer_table(c);
    if (c.typed && n == 1)
      expected_reports[expected_reports.size() - 1] = '{c.st, c.sl, 1'b1};
    if (gaps_on && $urandom_range(0, 2) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  // a mode 3 beat gives no result, so allow a full scan to drain as well
  task automatic wait_quiet();
    start <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_min_interval(input logic [DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    shadow_min_interval = value;
    cfg_valid <= 1'b0;
  endtask

  always @(posedge clk) begin : check_results
    timer_report_t want;
    if (!rst && result_strobe) begin
      if (expected_reports.size() == 0) begin
        flag_mismatch($sformatf("result status %0d slot %0d with none pending",
                                status, slot));
      end else begin
        want = expected_reports.pop_front();
        if (status !== want.st)
          flag_mismatch($sformatf("status %0d, expected %0d", status, want.st));
        if (slot !== want.sl)
          flag_mismatch($sformatf("slot %0d, expected %0d", slot, want.sl));
        if (last !== want.fin)
          flag_mismatch($sformatf("last %0b, expected %0b", last, want.fin));
      end
    end
  end

  initial begin : stimulus
    timer_cmd_t plan[$];
    timer_cmd_t c;
    logic [DATA_W-1:0] tick;
    int done_items;
    int pick;

    tick = 32'd500;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // op, interval, slot_id, now, typed, status, slot
    plan.push_back('{MODE_POLL, 32'd0, 6'd0, 32'd0, 1'b1, ST_NONE, 6'd0});
    plan.push_back('{MODE_SET, 32'd0, 6'd0, 32'd0, 1'b1, ST_SET_OK, 6'd0});
    plan.push_back('{MODE_SET, '1, '1, '1, 1'b1, ST_SET_OK, 6'd1});
    plan.push_back('{MODE_SET, 32'd5, 6'd0, 32'd100, 1'b1, ST_SET_OK, 6'd2});
    plan.push_back('{MODE_POLL, 32'd0, 6'd0, 32'd9, 1'b1, ST_NONE, 6'd0});
    // deadline equal to now counts as expired
    plan.push_back('{MODE_POLL, 32'd0, 6'd0, 32'd10, 1'b0, ST_SET_OK, 6'd0});
    plan.push_back('{MODE_CLEAR, 32'd0, 6'd63, 32'd0, 1'b1, ST_CLEARED, 6'd63});
    plan.push_back('{MODE_CLEAR, 32'd0, 6'd2, 32'd0, 1'b1, ST_CLEARED, 6'd2});
    plan.push_back('{MODE_UNUSED, '1, '1, '1, 1'b0, ST_SET_OK, 6'd0});
    // deadline wraps past zero
    plan.push_back('{MODE_SET, 32'd20, 6'd0, 32'hFFFF_FFF0, 1'b0, ST_SET_OK, 6'd0});
    plan.push_back('{MODE_POLL, 32'd0, 6'd0, '1, 1'b0, ST_SET_OK, 6'd0});
    plan.push_back('{MODE_POLL, 32'd0, 6'd0, 32'd0, 1'b1, ST_NONE, 6'd0});
    plan.push_back('{MODE_CLEAR, 32'd7, 6'd0, 32'd3, 1'b1, ST_CLEARED, 6'd0});
    plan.push_back('{MODE_SET, 32'd10, 6'd0, 32'h1234_5678, 1'b0, ST_SET_OK, 6'd0});

    for (int phase = 0; phase < 5; phase++) begin
      if (phase > 0) begin
        wait_quiet();
        case (phase)
          1: write_min_interval('0);
          2: write_min_interval('1);
          3: write_min_interval($urandom());
          default: write_min_interval($urandom_range(0, 60));
        endcase
      end
      gaps_on = (phase < 4);

      if (phase == 0) begin
        foreach (plan[k]) send_item(plan[k]);
        // fill every slot and run into overflow, then expire the whole table
        for (int k = 0; k < SLOT_COUNT; k++) begin
          c = '{MODE_SET, DATA_W'($urandom_range(0, 50)), '0, 32'd1000, 1'b0,
                ST_SET_OK, '0};
          send_item(c);
        end
        send_item('{MODE_SET, 32'd3, 6'd0, 32'd1000, 1'b1, ST_FULL, 6'd0});
        send_item('{MODE_POLL, 32'd0, 6'd0, '1, 1'b0, ST_SET_OK, 6'd0});
      end

      done_items = 0;
      while (done_items < ITEMS_PER_PHASE) begin
        pick = $urandom_range(0, 99);
        if ($urandom_range(0, 19) == 0) tick = $urandom();
        else tick += $urandom_range(0, 40);
        c = '{MODE_POLL, $urandom(), ID_W'($urandom()), tick, 1'b0, ST_SET_OK, '0};
        if ($urandom_range(0, 9) == 0) c.now = $urandom();
        if (pick < 40) begin
          c.op = MODE_SET;
          if ($urandom_range(0, 9) < 7) c.ivl = $urandom_range(0, 120);
        end else if (pick < 60) begin
          // low slots are the ones most likely to be live
          c.op = MODE_CLEAR;
          if ($urandom_range(0, 3) != 0) c.sid = ID_W'($urandom_range(0, 15));
        end else if (pick < 95) begin
          c.op = MODE_POLL;
        end else begin
          c.op = MODE_UNUSED;
        end
        send_item(c);
        if (c.op != MODE_UNUSED) done_items++;
        if (gaps_on && $urandom_range(0, 29) == 0 && expected_reports.size() != 0) begin
          start <= 1'b0;
          while (expected_reports.size() != 0) @(posedge clk);
        end
      end
    end

    start <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("one_shot_timer_table verification clean");
    end else begin
      $display("one_shot_timer_table verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("one_shot_timer_table verification failed");
    $finish;
  end

endmodule

`default_nettype wire
